// ===== sv/sps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and entry layout for the sprite priority sorter.
// ----------------------------------------------------------------------------
package sps_pkg;

    // capacity of the per-line sprite store
    localparam int MAX_SPRITES = 10;

    // field widths
    localparam int X_W       = 8;
    localparam int ATTR_W    = 6;
    localparam int PAYLOAD_W = 24;
    localparam int KEY_W     = X_W + ATTR_W;
    localparam int ENTRY_W   = KEY_W + PAYLOAD_W;

    // packed entry: {x, attr, payload}; the sort key is the upper KEY_W bits
    localparam int KEY_LSB   = PAYLOAD_W;
    localparam int ATTR_LSB  = PAYLOAD_W;
    localparam int X_LSB     = PAYLOAD_W + ATTR_W;

    // store addressing and fill count
    localparam int ADDR_W = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
    localparam int CNT_W  = $clog2(MAX_SPRITES + 1);

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;

endpackage

// ===== sv/sps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sps_ram #(
    parameter int DEPTH  = 10,
    parameter int WIDTH  = 38,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/sprite_priority_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_priority_sorter
// Insertion sort of one scanline's sprite entries, emitted by ascending x
// and then ascending attribute index.
// ----------------------------------------------------------------------------
// Entries are loaded with start while busy is low; an entry with last_entry
// set closes the set. Each entry is inserted at once into a single-port-read
// store kept in sorted order: the store is walked downward from the fill
// count, one read-compare-write per cycle, moving every entry with a larger
// key up by one. A load into an empty or full store is done on acceptance;
// otherwise busy stays high until the walk has written the new entry. Entries
// arriving at a full store (MAX_SPRITES) are dropped. After a closing beat the
// block reads the store out in order, one result per cycle on out_strobe,
// each registered from a store read; busy stays high while those reads are
// issued. Results cannot be held off: every strobed beat is final. Equal
// keys keep their arrival order.
// ----------------------------------------------------------------------------
module sprite_priority_sorter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [sps_pkg::X_W-1:0]          sprite_x,
    input  logic [sps_pkg::ATTR_W-1:0]       attr_index,
    input  logic [sps_pkg::PAYLOAD_W-1:0]    payload,
    input  logic                             last_entry,
    output logic                             out_strobe,
    output logic [sps_pkg::X_W-1:0]          out_x,
    output logic [sps_pkg::ATTR_W-1:0]       out_attr_index,
    output logic [sps_pkg::PAYLOAD_W-1:0]    out_payload,
    output logic                             out_last
);

    import sps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    cnt_t   held_reg, held_next;
    addr_t  pos_reg, pos_next;
    addr_t  emit_idx_reg, emit_idx_next;
    entry_t entry_reg, entry_next;
    logic   last_reg, last_next;
    logic   strobe_reg, strobe_next;
    logic   out_last_reg, out_last_next;

    // store ports
    logic   ram_we;
    addr_t  ram_waddr;
    entry_t ram_wdata;
    logic   ram_re;
    addr_t  ram_raddr;
    entry_t ram_rdata;

    logic   accept;
    entry_t new_entry;
    cnt_t   held_dec;
    logic   rd_key_gt;

    assign accept    = start && (state_reg == S_IDLE);
    assign new_entry = {sprite_x, attr_index, payload};
    assign held_dec  = held_reg - cnt_t'(1);
    assign rd_key_gt = ram_rdata[ENTRY_W-1:KEY_LSB] > entry_reg[ENTRY_W-1:KEY_LSB];

    sps_ram #(
        .DEPTH  (MAX_SPRITES),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: insertion walk and ordered readout
    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        pos_next      = pos_reg;
        emit_idx_next = emit_idx_reg;
        entry_next    = entry_reg;
        last_next     = last_reg;
        strobe_next   = 1'b0;
        out_last_next = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = entry_reg;
        ram_re        = 1'b0;
        ram_raddr     = emit_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    entry_next = new_entry;
                    last_next  = last_entry;
                    priority if (held_reg == cnt_t'(MAX_SPRITES))
                    begin
                        // full store: drop the entry
                        if (last_entry)
                        begin
                            emit_idx_next = '0;
                            state_next    = S_EMIT;
                        end
                    end
                    else if (held_reg == '0)
                    begin
                        // empty store: write straight to the head
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = new_entry;
                        held_next  = cnt_t'(1);
                        if (last_entry)
                        begin
                            emit_idx_next = '0;
                            state_next    = S_EMIT;
                        end
                    end
                    else
                    begin
                        // start the walk at the tail
                        ram_re     = 1'b1;
                        ram_raddr  = held_dec[ADDR_W-1:0];
                        pos_next   = held_reg[ADDR_W-1:0];
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // read data holds the entry just below pos
                ram_we = 1'b1;
                if (rd_key_gt)
                begin
                    ram_waddr = pos_reg;
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - addr_t'(1);
                    if (pos_reg == addr_t'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_reg - addr_t'(2);
                    end
                end
                else
                begin
                    ram_waddr     = pos_reg;
                    ram_wdata     = entry_reg;
                    held_next     = held_reg + cnt_t'(1);
                    emit_idx_next = '0;
                    state_next    = last_reg ? S_EMIT : S_IDLE;
                end
            end

            S_PLACE:
            begin
                ram_we        = 1'b1;
                ram_waddr     = pos_reg;
                ram_wdata     = entry_reg;
                held_next     = held_reg + cnt_t'(1);
                emit_idx_next = '0;
                state_next    = last_reg ? S_EMIT : S_IDLE;
            end

            S_EMIT:
            begin
                // one read per cycle; result shows with the read data
                ram_re        = 1'b1;
                ram_raddr     = emit_idx_reg;
                strobe_next   = 1'b1;
                out_last_next = (cnt_t'(emit_idx_reg) + cnt_t'(1)) == held_reg;
                if (out_last_next)
                begin
                    held_next     = '0;
                    emit_idx_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    emit_idx_next = emit_idx_reg + addr_t'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            pos_reg      <= '0;
            emit_idx_reg <= '0;
            last_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            pos_reg      <= pos_next;
            emit_idx_reg <= emit_idx_next;
            last_reg     <= last_next;
            strobe_reg   <= strobe_next;
            out_last_reg <= out_last_next;
        end
    end

    // entry being inserted
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign out_strobe     = strobe_reg;
    assign out_last       = out_last_reg;
    assign out_x          = ram_rdata[ENTRY_W-1:X_LSB];
    assign out_attr_index = ram_rdata[X_LSB-1:ATTR_LSB];
    assign out_payload    = ram_rdata[PAYLOAD_W-1:0];

`ifndef SYNTHESIS
    // fill count never exceeds capacity
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= cnt_t'(MAX_SPRITES))
        else $error("held count above capacity");

    // a result beat always follows a readout cycle
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> $past(state_reg == S_EMIT))
        else $error("result beat without readout");

    // the final beat of a set empties the store
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe && out_last |-> held_reg == '0)
        else $error("store not emptied after final beat");

    // the walk never looks below the head of the store
    a_walk_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> pos_reg != '0)
        else $error("insertion walk past head");

    // readout only starts with a nonempty store
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> held_reg != '0)
        else $error("readout of empty store");
`endif

endmodule
